[sv/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared sizes, types, result codes and slot index helpers of the sleep
// timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned SLOTS     = 16;
  localparam int unsigned TICK_BITS = 16;
  localparam int unsigned ID_BITS   = 8;

  localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W   = $clog2(SLOTS + 1);
  localparam int unsigned ENTRY_W = TICK_BITS + ID_BITS;

  // command codes of an input item
  localparam logic CMD_SLEEP = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SLEEP_OK   = 2'd0,
    KIND_SLEEP_FULL = 2'd1,
    KIND_WOKEN      = 2'd2,
    KIND_NO_WAKE    = 2'd3
  } kind_e;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [ID_BITS-1:0]   id_t;

  typedef struct packed {
    tick_t ticks;
    id_t   id;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] woken_thread;
    logic       yield_request;
    logic       last;
  } result_t;

  // circular slot index, one step up
  function automatic idx_t idx_next(idx_t i);
    if (i == idx_t'(SLOTS - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  // circular slot index, one step down
  function automatic idx_t idx_prev(idx_t i);
    if (i == '0) begin
      return idx_t'(SLOTS - 1);
    end
    return i - 1'b1;
  endfunction

  // circular slot index plus a fill count (count never above SLOTS)
  function automatic idx_t idx_add(idx_t a, cnt_t n);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(a) + (CNT_W + 1)'(n);
    if (s >= (CNT_W + 1)'(SLOTS)) begin
      s = s - (CNT_W + 1)'(SLOTS);
    end
    return s[IDX_W-1:0];
  endfunction

  // 8-bit thread id of the channel to the stored id width
  function automatic id_t port_to_id(logic [7:0] p);
    logic [15:0] w;
    w = 16'(p);
    return w[ID_BITS-1:0];
  endfunction

  // stored id back to the 8-bit result field
  function automatic logic [7:0] id_to_port(id_t i);
    logic [15:0] w;
    w = 16'(i);
    return w[7:0];
  endfunction

  // 16-bit tick count of the channel to the stored width, zero means one
  function automatic tick_t port_to_ticks(logic [15:0] p);
    logic [31:0] w;
    tick_t       t;
    w = 32'(p);
    t = w[TICK_BITS-1:0];
    if (t == '0) begin
      t = tick_t'(1);
    end
    return t;
  endfunction

endpackage

[sv/stt_in_if.sv]
// ----------------------------------------------------------------------------
// stt_in_if
// Command channel of the sleep timer table: sleep requests and timer ticks.
// ----------------------------------------------------------------------------
interface stt_in_if;

  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  thread_id;
  logic [15:0] sleep_ticks;
  logic        cpu_idle;

  modport source (
    output valid,
    output cmd,
    output thread_id,
    output sleep_ticks,
    output cpu_idle,
    input  ready
  );

  modport sink (
    input  valid,
    input  cmd,
    input  thread_id,
    input  sleep_ticks,
    input  cpu_idle,
    output ready
  );

endinterface

[sv/stt_out_if.sv]
// ----------------------------------------------------------------------------
// stt_out_if
// Result channel of the sleep timer table.
// ----------------------------------------------------------------------------
interface stt_out_if;

  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] woken_thread;
  logic       yield_request;
  logic       last;

  modport source (
    output valid,
    output kind,
    output woken_thread,
    output yield_request,
    output last,
    input  ready
  );

  modport sink (
    input  valid,
    input  kind,
    input  woken_thread,
    input  yield_request,
    input  last,
    output ready
  );

endinterface

[sv/stt_ram.sv]
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/stt_out_stage.sv]
// ----------------------------------------------------------------------------
// stt_out_stage
// Output register of the result channel; frees the walk from the sink.
// ----------------------------------------------------------------------------
module stt_out_stage import stt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    free_o,
  stt_out_if.source out_o
);

  logic    valid_q;
  result_t res_q;

  // slot is free when empty or being drained this cycle
  assign free_o = !valid_q || out_o.ready;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.woken_thread  = res_q.woken_thread;
  assign out_o.yield_request = res_q.yield_request;
  assign out_o.last          = res_q.last;

endmodule

[sv/stt_ctrl.sv]
// ----------------------------------------------------------------------------
// stt_ctrl
// Command sequencer: appends sleepers to a circular list in the table memory
// and walks it newest first on every tick, compacting the survivors.
// ----------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  stt_in_if.sink   in_i,
  input  logic     free_i,
  output logic     push_o,
  output result_t  res_o,
  output mem_req_t mem_o,
  input  entry_t   rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_PROC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  cnt_t       count_q, count_d;
  idx_t       base_q, base_d;
  idx_t       rd_q, rd_d;
  idx_t       wr_q, wr_d;
  cnt_t       left_q, left_d;
  cnt_t       kept_q, kept_d;
  logic       pend_q, pend_d;
  id_t        pend_id_q, pend_id_d;
  logic       yield_q, yield_d;

  logic       in_ready;
  logic       step;
  tick_t      dec;
  idx_t       newest;

  assign in_i.ready = in_ready;
  assign dec        = rdata_i.ticks - 1'b1;
  assign newest     = idx_prev(idx_add(base_q, count_q));

  // next state and memory requests
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    base_d    = base_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    left_d    = left_q;
    kept_d    = kept_q;
    pend_d    = pend_q;
    pend_id_d = pend_id_q;
    yield_d   = yield_q;
    in_ready  = 1'b0;
    step      = 1'b0;
    push_o    = 1'b0;
    res_o     = '{kind: KIND_SLEEP_OK, woken_thread: '0, yield_request: 1'b0, last: 1'b0};
    mem_o     = '0;

    case (state_q)
      S_IDLE: begin
        in_ready = free_i;
        if (in_i.valid && free_i) begin
          if (in_i.cmd == CMD_SLEEP) begin
            push_o     = 1'b1;
            res_o.last = 1'b1;
            if (count_q == cnt_t'(SLOTS)) begin
              res_o.kind = KIND_SLEEP_FULL;
            end else begin
              res_o.kind        = KIND_SLEEP_OK;
              mem_o.we          = 1'b1;
              mem_o.waddr       = idx_add(base_q, count_q);
              mem_o.wdata.ticks = port_to_ticks(in_i.sleep_ticks);
              mem_o.wdata.id    = port_to_id(in_i.thread_id);
              count_d           = count_q + 1'b1;
            end
          end else begin
            rd_d    = newest;
            wr_d    = newest;
            left_d  = count_q;
            kept_d  = '0;
            pend_d  = 1'b0;
            yield_d = !in_i.cpu_idle;
            state_d = (count_q == '0) ? S_DONE : S_RD;
          end
        end
      end

      S_RD: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = rd_q;
        state_d     = S_PROC;
      end

      S_PROC: begin
        if (dec != '0) begin
          // survivor moves down to the write pointer
          mem_o.we          = 1'b1;
          mem_o.waddr       = wr_q;
          mem_o.wdata.ticks = dec;
          mem_o.wdata.id    = rdata_i.id;
          wr_d              = idx_prev(wr_q);
          kept_d            = kept_q + 1'b1;
          step              = 1'b1;
        end else if (!pend_q || free_i) begin
          // a wake: send the one held back, hold this one
          if (pend_q) begin
            push_o             = 1'b1;
            res_o.kind         = KIND_WOKEN;
            res_o.woken_thread = id_to_port(pend_id_q);
          end
          pend_d    = 1'b1;
          pend_id_d = rdata_i.id;
          step      = 1'b1;
        end
        if (step) begin
          left_d  = left_q - 1'b1;
          rd_d    = idx_prev(rd_q);
          state_d = (left_q == cnt_t'(1)) ? S_DONE : S_RD;
        end
      end

      S_DONE: begin
        if (free_i) begin
          push_o              = 1'b1;
          res_o.last          = 1'b1;
          res_o.yield_request = yield_q;
          if (pend_q) begin
            res_o.kind         = KIND_WOKEN;
            res_o.woken_thread = id_to_port(pend_id_q);
          end else begin
            res_o.kind = KIND_NO_WAKE;
          end
          count_d = kept_q;
          base_d  = idx_next(wr_q);
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      base_q  <= '0;
      left_q  <= '0;
      kept_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      base_q  <= base_d;
      left_q  <= left_d;
      kept_q  <= kept_d;
      pend_q  <= pend_d;
    end
  end

  // walk pointers and held wake
  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    wr_q      <= wr_d;
    pend_id_q <= pend_id_d;
    yield_q   <= yield_d;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(SLOTS))
    else $error("fill count above table size");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> free_i)
    else $error("result pushed into a full output register");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= count_q)
    else $error("more survivors than entries");

  a_survivor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC && mem_o.we) |-> mem_o.wdata.ticks != '0)
    else $error("entry with zero ticks written back");

  a_read_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD |-> left_q != '0)
    else $error("table read with no entry left to walk");
`endif

endmodule

[sv/sleep_timer_table.sv]
// Sleep item: its result is registered and shown in the cycle after it is accepted.
// Tick item: one memory read (S_RD) and one update (S_PROC) per sleeping entry
// through the single read port, then S_DONE; wake results stream out.
// One item is worked on at a time; a result left waiting in the output register
// holds off the walk's next wake and the next item until the sink takes it.
// Reset clears the fill count and control state; the table memory is not
// cleared, as only filled entries are ever read.
// ----------------------------------------------------------------------------
// sleep_timer_table
// Table of sleeping threads with tick countdowns, kept as a circular list in
// one synchronous memory.
// ----------------------------------------------------------------------------
module sleep_timer_table import stt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_in_if.sink    in_i,
  stt_out_if.source out_o
);

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t             rdata;
  logic               push;
  logic               out_free;
  result_t            res;

  assign rdata = entry_t'(rdata_raw);

  // sequencer
  stt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .free_i  (out_free),
    .push_o  (push),
    .res_o   (res),
    .mem_o   (mem_req),
    .rdata_i (rdata)
  );

  // entry memory
  stt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata_raw)
  );

  // result register
  stt_out_stage u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule
